// ===== hw/rtl/ufsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufsf_pkg: shared types and constants of the spanning forest unit
// item layouts, request codes, front-to-back command record and range check
// ----------------------------------------------------------------------------
package ufsf_pkg;

  localparam int unsigned VW               = 10;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned DEF_NUM_VERTICES = 1024;

  // command queue between front and back, depth must be a power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [VW-1:0]     vtx_t;
  typedef logic [KIND_W-1:0] kind_t;

  // request codes
  localparam kind_t REQ_EDGE  = 2'd0;
  localparam kind_t REQ_WRITE = 2'd1;
  localparam kind_t REQ_READ  = 2'd2;
  localparam kind_t REQ_NONE  = 2'd3;

  typedef struct packed {
    kind_t req_type;
    vtx_t  vertex_a;
    vtx_t  vertex_b;
    vtx_t  parent_in;
  } in_item_t;

  typedef struct packed {
    kind_t result_kind;
    logic  is_tree_edge;
    vtx_t  edge_a;
    vtx_t  edge_b;
    vtx_t  parent_out;
  } out_item_t;

  // classified request as it waits in the command queue
  typedef struct packed {
    kind_t kind;
    vtx_t  a;
    vtx_t  b;
    vtx_t  pin;
    logic  a_ok;
    logic  b_ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_stat_t;

  function automatic logic in_range(input vtx_t v, input int unsigned lim);
    return 32'(v) < lim;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ufsf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufsf_front: request intake
// range-checks each request and holds it in a short command queue
// ----------------------------------------------------------------------------
module ufsf_front #(
  parameter int unsigned NUM_VERTICES = ufsf_pkg::DEF_NUM_VERTICES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire ufsf_pkg::in_item_t in_item,
  output ufsf_pkg::q_head_t       q_head,
  input  wire ufsf_pkg::bk_stat_t bk_stat
);

  ufsf_pkg::cmd_t                  q_r [ufsf_pkg::QUEUE_DEPTH];
  logic [ufsf_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ufsf_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ufsf_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            push_ok;
  ufsf_pkg::cmd_t                  cmd_in;

  assign in_full = (cnt_r == ufsf_pkg::QCNT_W'(ufsf_pkg::QUEUE_DEPTH)) || bk_stat.clearing;
  assign push_ok = in_push && !in_full;

  // classify
  always_comb begin
    cmd_in.kind = in_item.req_type;
    cmd_in.a    = in_item.vertex_a;
    cmd_in.b    = in_item.vertex_b;
    cmd_in.pin  = in_item.parent_in;
    cmd_in.a_ok = ufsf_pkg::in_range(in_item.vertex_a, NUM_VERTICES);
    cmd_in.b_ok = ufsf_pkg::in_range(in_item.vertex_b, NUM_VERTICES);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = wr_ptr_r + ufsf_pkg::QPTR_W'(1);
    end
    if (bk_stat.pop) begin
      rd_ptr_nxt = rd_ptr_r + ufsf_pkg::QPTR_W'(1);
    end
    if (push_ok && !bk_stat.pop) begin
      cnt_nxt = cnt_r + ufsf_pkg::QCNT_W'(1);
    end else if (!push_ok && bk_stat.pop) begin
      cnt_nxt = cnt_r - ufsf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.cmd   = q_r[rd_ptr_r];

endmodule
`default_nettype wire

// ===== hw/rtl/ufsf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufsf_back: parent store and walk sequencer
// clears the store after reset, runs writes, reads and splicing walks
// ----------------------------------------------------------------------------
module ufsf_back #(
  parameter int unsigned NUM_VERTICES = ufsf_pkg::DEF_NUM_VERTICES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ufsf_pkg::q_head_t  q_head,
  output ufsf_pkg::bk_stat_t      bk_stat,
  input  wire logic               out_pop,
  output logic                    out_valid,
  output ufsf_pkg::out_item_t     out_item
);

  localparam int unsigned AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        steps_r, steps_nxt;
  ufsf_pkg::vtx_t       x_r, x_nxt;
  ufsf_pkg::vtx_t       y_r, y_nxt;
  ufsf_pkg::cmd_t       cur_r, cur_nxt;
  ufsf_pkg::vtx_t       parent_mem_r [NUM_VERTICES];
  ufsf_pkg::vtx_t       rd_a_r, rd_b_r;
  logic                 out_valid_r;
  ufsf_pkg::out_item_t  out_item_r;

  logic                 we;
  logic [AW-1:0]        wa;
  ufsf_pkg::vtx_t       wd;
  logic [AW-1:0]        ra_a, ra_b;
  logic                 slot_free;
  logic                 load;
  logic                 done;
  logic                 tree;
  logic                 pop;
  ufsf_pkg::out_item_t  res;
  ufsf_pkg::vtx_t       px, py;

  function automatic logic [AW-1:0] vaddr(input ufsf_pkg::vtx_t v);
    return AW'(v);
  endfunction

  assign slot_free = !out_valid_r || out_pop;
  assign px        = rd_a_r;
  assign py        = rd_b_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    steps_nxt = steps_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cur_nxt   = cur_r;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    pop       = 1'b0;
    load      = 1'b0;
    done      = 1'b0;
    tree      = 1'b0;
    res       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = ufsf_pkg::VW'(clr_r);
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(NUM_VERTICES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_head.valid && slot_free) begin
          pop       = 1'b1;
          cur_nxt   = q_head.cmd;
          x_nxt     = q_head.cmd.a;
          y_nxt     = q_head.cmd.b;
          steps_nxt = '0;
          unique case (q_head.cmd.kind)
            ufsf_pkg::REQ_EDGE: begin
              if (q_head.cmd.a_ok && q_head.cmd.b_ok) begin
                state_nxt = ST_WALK;
              end else begin
                load            = 1'b1;
                res.result_kind = ufsf_pkg::REQ_EDGE;
                res.edge_a      = q_head.cmd.a;
                res.edge_b      = q_head.cmd.b;
              end
            end
            ufsf_pkg::REQ_WRITE: begin
              if (q_head.cmd.a_ok) begin
                we = 1'b1;
                wa = vaddr(q_head.cmd.a);
                wd = q_head.cmd.pin;
              end
              load            = 1'b1;
              res.result_kind = ufsf_pkg::REQ_WRITE;
            end
            ufsf_pkg::REQ_READ: begin
              if (q_head.cmd.a_ok) begin
                state_nxt = ST_READ;
              end else begin
                load            = 1'b1;
                res.result_kind = ufsf_pkg::REQ_READ;
              end
            end
            default: begin
              load            = 1'b1;
              res.result_kind = q_head.cmd.kind;
            end
          endcase
        end
      end
      ST_READ: begin
        load            = 1'b1;
        res.result_kind = ufsf_pkg::REQ_READ;
        res.parent_out  = rd_a_r;
        state_nxt       = ST_IDLE;
      end
      default: begin
        // one compare-and-move step per cycle
        steps_nxt = steps_r + AW'(1);
        if (px == py) begin
          done = 1'b1;
        end else if (px < py) begin
          we = 1'b1;
          wa = vaddr(x_r);
          wd = py;
          if (x_r == px) begin
            done = 1'b1;
            tree = 1'b1;
          end else if (!ufsf_pkg::in_range(px, NUM_VERTICES)) begin
            done = 1'b1;
          end else begin
            x_nxt = px;
          end
        end else begin
          we = 1'b1;
          wa = vaddr(y_r);
          wd = px;
          if (y_r == py) begin
            done = 1'b1;
            tree = 1'b1;
          end else if (!ufsf_pkg::in_range(py, NUM_VERTICES)) begin
            done = 1'b1;
          end else begin
            y_nxt = py;
          end
        end
        // step budget used up
        if (!done && (steps_r == AW'(NUM_VERTICES - 1))) begin
          done = 1'b1;
        end
        if (done) begin
          load             = 1'b1;
          res.result_kind  = ufsf_pkg::REQ_EDGE;
          res.is_tree_edge = tree;
          res.edge_a       = cur_r.a;
          res.edge_b       = cur_r.b;
          state_nxt        = ST_IDLE;
        end
      end
    endcase
  end

  // next step's fetch goes out with this step's splice; while the walk goes on, never to the same entry
  assign ra_a = vaddr(x_nxt);
  assign ra_b = vaddr(y_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    cur_r   <= cur_nxt;
    if (load) begin
      out_item_r <= res;
    end
  end

  // parent store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      parent_mem_r[wa] <= wd;
    end
    rd_a_r <= parent_mem_r[ra_a];
    rd_b_r <= parent_mem_r[ra_b];
  end

  assign bk_stat.pop      = pop;
  assign bk_stat.clearing = (state_r == ST_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_item         = out_item_r;

endmodule
`default_nettype wire

// ===== hw/rtl/union_find_spanning_forest_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_spanning_forest_unit: spanning forest builder over a parent store
// Rem's union-find with splicing; edge, write and read requests
// ----------------------------------------------------------------------------
// After reset the unit sweeps its parent store to the identity, one entry a
// cycle, and in_full stays high until the sweep is over. Requests then queue
// in a four-deep command queue and are carried out one at a time by the back
// end, which owns a parent memory with one write port and two registered read
// ports. A write, an unknown request or an edge with an endpoint out of range
// completes in the back end's idle state, a read passes on to a read state,
// and an edge runs a walk of compare-and-move steps (1 to NUM_VERTICES steps);
// one step a cycle is what the memory ports allow, since each step splices one
// entry and fetches the two parents for the next. Each result sits in an
// output register, so new requests keep flowing in while a result waits to be
// popped. Results come out in request order, one per request.
// ----------------------------------------------------------------------------
module union_find_spanning_forest_unit #(
  parameter int unsigned NUM_VERTICES = ufsf_pkg::DEF_NUM_VERTICES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request side
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire ufsf_pkg::in_item_t  in_item,
  // result side
  output logic                     out_empty,
  input  wire logic                out_pop,
  output ufsf_pkg::out_item_t      out_item
);

  ufsf_pkg::q_head_t  q_head;
  ufsf_pkg::bk_stat_t bk_stat;
  logic               out_valid;

  // intake and classification
  ufsf_front #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_head  (q_head),
    .bk_stat (bk_stat)
  );

  // store, walk sequencer and result register
  ufsf_back #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .bk_stat   (bk_stat),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_empty = !out_valid;

  // back end only takes a command the queue really holds
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> q_head.valid)
    else $error("command queue popped while empty");

  // reset always starts the store sweep
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> bk_stat.clearing)
    else $error("store sweep not started by reset");

  // no transfer accepted while the store is being initialized
  a_clear_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> in_full)
    else $error("request side open during store sweep");

  // nothing can be produced before the sweep ends
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> out_empty)
    else $error("result present during store sweep");

endmodule
`default_nettype wire
